// ===== rtl/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types, codes and constants of the peak cluster selector.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int NPEAK  = 64;
    localparam int NCLUS  = 16;
    localparam int PKW    = 6;
    localparam int LBW    = 4;
    localparam int SIMW   = 16;
    localparam int SUMW   = 32;
    localparam int CNTW   = 12;
    localparam int PAW    = 8;
    localparam int SIMAW  = 12;
    localparam int DVDW   = 32;
    localparam int DVSW   = 16;
    localparam int SILW   = 17;
    localparam int OTHW   = 20;

    // threshold clamp, round(0.3 * 2^16) and round(0.6 * 2^16)
    localparam logic [SIMW-1:0] TH_LO = 16'd19661;
    localparam logic [SIMW-1:0] TH_HI = 16'd39322;

    // floor(2^16 / C), indexed by C - 1
    localparam logic [SILW-1:0] SIL_TH [NCLUS] = '{
        17'd65536, 17'd32768, 17'd21845, 17'd16384,
        17'd13107, 17'd10922, 17'd9362,  17'd8192,
        17'd7281,  17'd6553,  17'd5957,  17'd5461,
        17'd5041,  17'd4681,  17'd4369,  17'd4096
    };

    localparam logic CFG_PEAK_COUNT = 1'b0;
    localparam logic CFG_KEEP_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD_LABEL = 2'd0,
        OP_LOAD_SIM   = 2'd1,
        OP_RUN        = 2'd2,
        OP_NOP        = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        D_NONE, D_START, D_CLEAR, D_CMAX, D_PAIR_INIT, D_ROW_LAT,
        D_P_RD, D_P_LAT, D_P_WR, D_P_SKIP, D_K_INIT, D_A_RD,
        D_A_ZERO, D_A_DIV, D_A_ACC, D_K_FIN1, D_K_FIN2, D_O_TAKE,
        D_SIL_ZERO, D_M_DIV, D_SIL_SET, D_R_INIT, D_R_STEP, D_DECIDE,
        D_EMIT
    } t_dop;

    typedef struct packed {
        t_dop op;
        logic ld_label;
        logic ld_sim;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic a_last;
        logic b_last;
        logic b_eq_a;
        logic i_last;
        logic k_last;
        logic cnt_zero;
        logic c_single;
        logic m_zero;
        logic div_done;
        logic out_free;
    } t_stat;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_CMAX, S_CMAX_TL, S_ROW_RD, S_ROW_LAT,
        S_P_RD, S_P_LAT, S_P_SUM, S_P_WR, S_K_INIT, S_A_RD,
        S_A_CHK, S_A_WAIT, S_K_FIN, S_O_WAIT, S_M_CHK, S_M_WAIT,
        S_R_INIT, S_R_STEP, S_DECIDE, S_E_RD, S_E_LAT
    } t_state;

endpackage

// ===== rtl/peak_cluster_selector_core.sv =====
// ----------------------------------------------------------------------------
// peak_cluster_selector_core
// Scores peak clusters by similarity and labels each peak kept or dropped.
// ----------------------------------------------------------------------------
// Label and similarity load words are taken one per cycle while the block is
// idle. A run word stalls the input until the last label word has been
// issued. A run clears all 256 pair sums, scans the labels for the cluster
// count, accumulates every off-diagonal peak pair (the diagonal is skipped)
// through the pair sum memory, then divides for each nonzero cluster-pair
// average and for each cluster's coefficient, all on one shared 32-step
// divider, then ranks and selects the clusters and emits one word per peak.
module peak_cluster_selector_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [6:0]               i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_op,
    input  logic [pcs_pkg::PKW-1:0]  i_peak_index,
    input  logic [pcs_pkg::PKW-1:0]  i_other_index,
    input  logic [pcs_pkg::LBW-1:0]  i_cluster_label,
    input  logic [pcs_pkg::SIMW-1:0] i_similarity_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [pcs_pkg::PKW-1:0]  o_out_peak,
    output logic signed [4:0]        o_out_label,
    output logic                     o_last
);
    import pcs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pcs_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_peak_index       (i_peak_index),
        .i_other_index      (i_other_index),
        .i_cluster_label    (i_cluster_label),
        .i_similarity_value (i_similarity_value),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_out_peak         (o_out_peak),
        .o_out_label        (o_out_label),
        .o_last             (o_last)
    );
endmodule

// ===== rtl/pcs_ram.sv =====
// ----------------------------------------------------------------------------
// pcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcs_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ===== rtl/pcs_div.sv =====
// ----------------------------------------------------------------------------
// pcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcs_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [pcs_pkg::DVDW-1:0] i_dividend,
    input  logic [pcs_pkg::DVSW-1:0] i_divisor,
    output logic                     o_done,
    output logic [pcs_pkg::DVDW-1:0] o_quot
);
    import pcs_pkg::*;

    localparam int CW = $clog2(DVDW);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [DVDW-1:0] r_quo;
    logic [DVSW-1:0] r_rem;
    logic [DVSW-1:0] r_dvs;
    logic [DVSW:0]   sh;
    logic [DVSW+1:0] trial;
    logic            ge;

    assign sh    = {r_rem, r_quo[DVDW-1]};
    assign trial = {1'b0, sh} - {2'b00, r_dvs};
    assign ge    = !trial[DVSW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVDW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVDW-2:0], ge};
            r_rem <= ge ? trial[DVSW-1:0] : sh[DVSW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ===== rtl/pcs_dp.sv =====
// ----------------------------------------------------------------------------
// pcs_dp
// Datapath: stores, pair accumulation, coefficients, ranking, selection, output.
// ----------------------------------------------------------------------------
module pcs_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pcs_pkg::t_cmd              i_cmd,
    output pcs_pkg::t_stat             o_stat,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [6:0]                 i_cfg_data,
    input  logic [pcs_pkg::PKW-1:0]    i_peak_index,
    input  logic [pcs_pkg::PKW-1:0]    i_other_index,
    input  logic [pcs_pkg::LBW-1:0]    i_cluster_label,
    input  logic [pcs_pkg::SIMW-1:0]   i_similarity_value,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [pcs_pkg::PKW-1:0]    o_out_peak,
    output logic signed [4:0]          o_out_label,
    output logic                       o_last
);
    import pcs_pkg::*;

    // control
    logic [PAW-1:0]  r_a;
    logic [PKW-1:0]  r_b;
    logic [6:0]      r_n;
    logic [6:0]      r_pc;
    logic [4:0]      r_kc;
    logic [4:0]      r_c;
    logic            r_lv;
    logic            r_ovalid;
    // payload
    logic [LBW-1:0]  r_li;
    logic [PAW-1:0]  r_pa;
    logic [SIMW-1:0] r_sim;
    logic [SIMW-1:0] r_self;
    logic [OTHW-1:0] r_other;
    logic [SIMW-1:0] r_intra [NCLUS];
    logic [SILW-1:0] r_sil [NCLUS];
    logic [LBW-1:0]  r_rank [NCLUS];
    logic [NCLUS-1:0] r_keep;
    logic [SIMW-1:0] r_min;
    logic [SIMW-1:0] r_max;
    logic [PKW-1:0]  r_opeak;
    logic [4:0]      r_olabel;
    logic            r_olast;

    logic [LBW-1:0]  lab_q;
    logic [SIMW-1:0] sim_q;
    logic [SUMW-1:0] sum_q;
    logic [CNTW-1:0] cnt_q;
    logic [PKW-1:0]  lab_raddr;
    logic            pr_we;
    logic [PAW-1:0]  pr_waddr;
    logic [PAW-1:0]  pr_raddr;
    logic [SUMW-1:0] sum_wdata;
    logic [CNTW-1:0] cnt_wdata;

    logic            div_start;
    logic [DVDW-1:0] div_dvd;
    logic [DVSW-1:0] div_dvs;
    logic            div_done;
    logic [DVDW-1:0] div_q;

    logic [6:0]      n_clamp;
    logic [6:0]      n_m1;
    logic [4:0]      c_m1;
    logic [LBW-1:0]  k;
    logic            b_last;
    logic            a_last;
    logic [SIMW-1:0] oth16;
    logic [SIMW-1:0] m_val;
    logic [SIMW-1:0] mag;
    logic [SILW-1:0] q_sat;
    logic [SILW-1:0] sil_new;
    logic [SIMW:0]   th_sum;
    logic [SIMW-1:0] th;
    logic [SILW-1:0] sth;
    logic [NCLUS-1:0] lane_mask;
    logic [NCLUS-1:0] drop_t;
    logic [NCLUS-1:0] drop_c;
    logic [NCLUS-1:0] rank0;
    logic [NCLUS-1:0] keep_new;
    logic [SIMW-1:0] ij;
    logic [4:0]      lab_ext;
    logic [4:0]      olabel_new;

    pcs_ram #(.W(LBW), .D(NPEAK)) u_lab (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_label),
        .i_waddr (i_peak_index),
        .i_wdata (i_cluster_label),
        .i_raddr (lab_raddr),
        .o_rdata (lab_q)
    );

    pcs_ram #(.W(SIMW), .D(NPEAK * NPEAK)) u_sim (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_sim),
        .i_waddr ({i_peak_index, i_other_index}),
        .i_wdata (i_similarity_value),
        .i_raddr ({r_a[PKW-1:0], r_b}),
        .o_rdata (sim_q)
    );

    pcs_ram #(.W(SUMW), .D(NCLUS * NCLUS)) u_sum (
        .i_clk   (i_clk),
        .i_we    (pr_we),
        .i_waddr (pr_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (pr_raddr),
        .o_rdata (sum_q)
    );

    pcs_ram #(.W(CNTW), .D(NCLUS * NCLUS)) u_cnt (
        .i_clk   (i_clk),
        .i_we    (pr_we),
        .i_waddr (pr_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (pr_raddr),
        .o_rdata (cnt_q)
    );

    pcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign lab_raddr = (i_cmd.op == D_P_RD) ? r_b : r_a[PKW-1:0];
    assign pr_we     = (i_cmd.op == D_CLEAR) || (i_cmd.op == D_P_WR);
    assign pr_waddr  = (i_cmd.op == D_CLEAR) ? r_a : r_pa;
    assign pr_raddr  = (i_cmd.op == D_A_RD) ? {r_a[LBW-1:0], r_b[LBW-1:0]} : r_pa;
    assign sum_wdata = (i_cmd.op == D_CLEAR) ? '0 : sum_q + SUMW'(r_sim);
    assign cnt_wdata = (i_cmd.op == D_CLEAR) ? '0 : cnt_q + 1'b1;

    assign n_clamp = (r_pc == 7'd0) ? 7'd1 : (r_pc > 7'(NPEAK)) ? 7'(NPEAK) : r_pc;
    assign n_m1    = r_n - 7'd1;
    assign c_m1    = r_c - 5'd1;
    assign k       = r_a[LBW-1:0];
    assign a_last  = (r_a == {1'b0, n_m1});
    assign b_last  = ({1'b0, r_b} == n_m1);

    // coefficient arithmetic
    assign oth16 = r_other[SIMW-1:0];
    assign m_val = (r_self > oth16) ? r_self : oth16;
    assign mag   = (r_self >= oth16) ? r_self - oth16 : oth16 - r_self;
    assign q_sat = (div_q > DVDW'(17'h10000)) ? 17'h10000 : div_q[SILW-1:0];
    assign sil_new = (r_self >= oth16) ?
                     ((q_sat > 17'h0FFFF) ? 17'h0FFFF : q_sat) :
                     (~q_sat + 1'b1);

    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        case (i_cmd.op)
            D_A_DIV: begin
                div_start = 1'b1;
                div_dvd   = sum_q;
                div_dvs   = DVSW'(cnt_q);
            end
            D_K_FIN2: begin
                div_start = 1'b1;
                div_dvd   = DVDW'(r_other);
                div_dvs   = DVSW'(c_m1);
            end
            D_M_DIV: begin
                div_start = 1'b1;
                div_dvd   = {mag, {SIMW{1'b0}}};
                div_dvs   = m_val;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // selection
    assign th_sum = {1'b0, r_min} + {1'b0, r_max};
    assign th     = (th_sum[SIMW:1] > TH_HI) ? TH_HI :
                    (th_sum[SIMW:1] < TH_LO) ? TH_LO : th_sum[SIMW:1];
    assign sth    = SIL_TH[c_m1[LBW-1:0]];
    assign ij     = r_intra[r_b[LBW-1:0]];

    always_comb begin
        for (int l = 0; l < NCLUS; l++) begin
            lane_mask[l] = (5'(l) < r_c);
            drop_t[l] = lane_mask[l] && ((r_intra[l] < th) ||
                        ($signed({r_sil[l][SILW-1], r_sil[l]}) < $signed({1'b0, sth})));
            rank0[l]  = lane_mask[l] && (r_rank[l] == '0);
            drop_c[l] = lane_mask[l] &&
                        (({2'b00, r_rank[l]} + {1'b0, r_kc}) < {1'b0, r_c});
        end
        if (r_kc == 5'd0) begin
            keep_new = ~(drop_t | ((drop_t == '0) ? rank0 : '0));
        end else begin
            keep_new = ~drop_c;
        end
    end

    assign lab_ext    = {1'b0, lab_q};
    assign olabel_new = r_keep[lab_q] ? lab_ext :
                        (lab_q == '0) ? 5'h1F : (~lab_ext + 5'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a      <= '0;
            r_b      <= '0;
            r_n      <= 7'(NPEAK);
            r_c      <= 5'd1;
            r_lv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_pc     <= 7'(NPEAK);
            r_kc     <= 5'd1;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PEAK_COUNT) begin
                    r_pc <= i_cfg_data;
                end else begin
                    r_kc <= i_cfg_data[4:0];
                end
            end
            r_lv <= (i_cmd.op == D_CMAX);
            if (r_lv && ((lab_ext + 5'd1) > r_c)) begin
                r_c <= lab_ext + 5'd1;
            end
            if (i_cmd.op == D_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                D_START: begin
                    r_a <= '0;
                    r_b <= '0;
                    r_c <= '0;
                    r_n <= n_clamp;
                end
                D_CLEAR, D_CMAX, D_EMIT: begin
                    r_a <= r_a + 1'b1;
                end
                D_PAIR_INIT, D_K_INIT: begin
                    r_a <= '0;
                    r_b <= '0;
                end
                D_P_WR, D_P_SKIP: begin
                    if (b_last) begin
                        r_b <= '0;
                        r_a <= r_a + 1'b1;
                    end else begin
                        r_b <= r_b + 1'b1;
                    end
                end
                D_A_ZERO, D_A_ACC, D_R_STEP: begin
                    r_b <= r_b + 1'b1;
                end
                D_K_FIN1, D_SIL_ZERO, D_SIL_SET: begin
                    r_a <= r_a + 1'b1;
                    r_b <= '0;
                end
                D_R_INIT: begin
                    r_b <= '0;
                end
                D_DECIDE: begin
                    r_a <= '0;
                end
                default: begin
                    r_a <= r_a;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            D_ROW_LAT: begin
                r_li <= lab_q;
            end
            D_P_LAT: begin
                r_pa  <= {r_li, lab_q};
                r_sim <= sim_q;
            end
            D_K_INIT: begin
                r_self  <= '0;
                r_other <= '0;
            end
            D_A_ACC: begin
                if (r_b == r_a[PKW-1:0]) begin
                    r_self <= div_q[SIMW-1:0];
                end else begin
                    r_other <= r_other + div_q[OTHW-1:0];
                end
            end
            D_K_FIN1: begin
                r_intra[k] <= r_self;
                r_sil[k]   <= '0;
                r_self     <= '0;
                r_other    <= '0;
            end
            D_K_FIN2: begin
                r_intra[k] <= r_self;
            end
            D_O_TAKE: begin
                r_other <= div_q[OTHW-1:0];
            end
            D_SIL_ZERO: begin
                r_sil[k] <= '0;
                r_self   <= '0;
                r_other  <= '0;
            end
            D_SIL_SET: begin
                r_sil[k] <= sil_new;
                r_self   <= '0;
                r_other  <= '0;
            end
            D_R_INIT: begin
                for (int l = 0; l < NCLUS; l++) begin
                    r_rank[l] <= '0;
                end
                r_min <= '1;
                r_max <= '0;
            end
            D_R_STEP: begin
                // stable rank: smaller intra first, lower index wins a tie
                for (int l = 0; l < NCLUS; l++) begin
                    if ((ij < r_intra[l]) ||
                        ((ij == r_intra[l]) && (r_b[LBW-1:0] < LBW'(l)))) begin
                        r_rank[l] <= r_rank[l] + 1'b1;
                    end
                end
                if (ij < r_min) begin
                    r_min <= ij;
                end
                if (ij > r_max) begin
                    r_max <= ij;
                end
            end
            D_DECIDE: begin
                r_keep <= keep_new;
            end
            D_EMIT: begin
                r_opeak  <= r_a[PKW-1:0];
                r_olabel <= olabel_new;
                r_olast  <= a_last;
            end
            default: begin
                r_li <= r_li;
            end
        endcase
    end

    assign o_stat.clr_last = (r_a == '1);
    assign o_stat.a_last   = a_last;
    assign o_stat.b_last   = b_last;
    assign o_stat.b_eq_a   = (r_b == r_a[PKW-1:0]);
    assign o_stat.i_last   = (r_b == {1'b0, c_m1});
    assign o_stat.k_last   = (r_a == {3'b000, c_m1});
    assign o_stat.cnt_zero = (cnt_q == '0);
    assign o_stat.c_single = (r_c < 5'd2);
    assign o_stat.m_zero   = (m_val == '0);
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_ovalid || !i_stall;

    assign o_valid     = r_ovalid;
    assign o_out_peak  = r_opeak;
    assign o_out_label = $signed(r_olabel);
    assign o_last      = r_olast;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == D_EMIT) |-> (!r_ovalid || !i_stall))
        else $error("word latched over a pending word");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == D_K_INIT) |-> ((r_c != 5'd0) && (r_c <= 5'(NCLUS))))
        else $error("cluster count out of range");

    a_auto_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.op == D_DECIDE) && (r_kc == 5'd0)) |=> ((~r_keep & lane_mask) != '0))
        else $error("threshold mode kept every cluster");
endmodule

// ===== rtl/pcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer: steps the datapath through clear, accumulate, score, emit.
// ----------------------------------------------------------------------------
module pcs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_op,
    output logic           o_stall,
    input  pcs_pkg::t_stat i_stat,
    output pcs_pkg::t_cmd  o_cmd
);
    import pcs_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state pair_next;
    t_state k_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign pair_next = i_stat.b_last ? (i_stat.a_last ? S_K_INIT : S_ROW_RD) : S_P_RD;
    assign k_next    = i_stat.k_last ? S_R_INIT : S_A_RD;
    assign o_stall   = (r_state != S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = D_NONE;
        o_cmd.ld_label = 1'b0;
        o_cmd.ld_sim   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld_label = (i_op == OP_LOAD_LABEL);
                    o_cmd.ld_sim   = (i_op == OP_LOAD_SIM);
                    if (i_op == OP_RUN) begin
                        o_cmd.op = D_START;
                        n_state  = S_CLR;
                    end
                end
            end
            S_CLR: begin
                o_cmd.op = D_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_CMAX;
                end
            end
            S_CMAX: begin
                o_cmd.op = D_CMAX;
                if (i_stat.a_last) begin
                    n_state = S_CMAX_TL;
                end
            end
            S_CMAX_TL: begin
                o_cmd.op = D_PAIR_INIT;
                n_state  = S_ROW_RD;
            end
            S_ROW_RD: begin
                n_state = S_ROW_LAT;
            end
            S_ROW_LAT: begin
                o_cmd.op = D_ROW_LAT;
                n_state  = S_P_RD;
            end
            S_P_RD: begin
                if (i_stat.b_eq_a) begin
                    o_cmd.op = D_P_SKIP;
                    n_state  = pair_next;
                end else begin
                    o_cmd.op = D_P_RD;
                    n_state  = S_P_LAT;
                end
            end
            S_P_LAT: begin
                o_cmd.op = D_P_LAT;
                n_state  = S_P_SUM;
            end
            S_P_SUM: begin
                n_state = S_P_WR;
            end
            S_P_WR: begin
                o_cmd.op = D_P_WR;
                n_state  = pair_next;
            end
            S_K_INIT: begin
                o_cmd.op = D_K_INIT;
                n_state  = S_A_RD;
            end
            S_A_RD: begin
                o_cmd.op = D_A_RD;
                n_state  = S_A_CHK;
            end
            S_A_CHK: begin
                if (i_stat.cnt_zero) begin
                    o_cmd.op = D_A_ZERO;
                    n_state  = i_stat.i_last ? S_K_FIN : S_A_RD;
                end else begin
                    o_cmd.op = D_A_DIV;
                    n_state  = S_A_WAIT;
                end
            end
            S_A_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = D_A_ACC;
                    n_state  = i_stat.i_last ? S_K_FIN : S_A_RD;
                end
            end
            S_K_FIN: begin
                if (i_stat.c_single) begin
                    o_cmd.op = D_K_FIN1;
                    n_state  = k_next;
                end else begin
                    o_cmd.op = D_K_FIN2;
                    n_state  = S_O_WAIT;
                end
            end
            S_O_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = D_O_TAKE;
                    n_state  = S_M_CHK;
                end
            end
            S_M_CHK: begin
                if (i_stat.m_zero) begin
                    o_cmd.op = D_SIL_ZERO;
                    n_state  = k_next;
                end else begin
                    o_cmd.op = D_M_DIV;
                    n_state  = S_M_WAIT;
                end
            end
            S_M_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = D_SIL_SET;
                    n_state  = k_next;
                end
            end
            S_R_INIT: begin
                o_cmd.op = D_R_INIT;
                n_state  = S_R_STEP;
            end
            S_R_STEP: begin
                o_cmd.op = D_R_STEP;
                if (i_stat.i_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.op = D_DECIDE;
                n_state  = S_E_RD;
            end
            S_E_RD: begin
                n_state = S_E_LAT;
            end
            S_E_LAT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = D_EMIT;
                    n_state  = i_stat.a_last ? S_IDLE : S_E_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ===== bench/peak_cluster_selector_core_test.sv =====
// ----------------------------------------------------------------------------
// peak_cluster_selector_core_test
// Self-checking bench for the peak cluster selector core. The label and
// similarity stores are filled first, then a directed table and random
// load/run sequences are pushed through the input port under varying
// settings; every emitted label word is checked against a predictor.
// ----------------------------------------------------------------------------
module peak_cluster_selector_core_test;
    import pcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int RAND_ITEMS  = 180;
    // runs never use more peaks than this, so the fill stays small
    localparam int TB_PEAKS    = 16;

    typedef struct packed {
        logic [PKW-1:0]    peak;
        logic signed [4:0] lab;
        logic              last;
    } t_label_word;

    typedef struct {
        bit                 cfg;
        logic [6:0]         pc;
        logic [6:0]         kc;
        t_op                op;
        logic [PKW-1:0]     pi;
        logic [PKW-1:0]     oi;
        logic [LBW-1:0]     lab;
        logic [SIMW-1:0]    sim;
        bit                 typed;
        logic signed [4:0]  l0;
        logic signed [4:0]  l1;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_index = 1'b0;
    logic [6:0]          i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [1:0]          i_op = '0;
    logic [PKW-1:0]      i_peak_index = '0;
    logic [PKW-1:0]      i_other_index = '0;
    logic [LBW-1:0]      i_cluster_label = '0;
    logic [SIMW-1:0]     i_similarity_value = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [PKW-1:0]      o_out_peak;
    logic signed [4:0]   o_out_label;
    logic                o_last;

    peak_cluster_selector_core u_dut (.*);

    // predictor copy of stores and settings
    logic [LBW-1:0]  lab_mem [NPEAK];
    logic [SIMW-1:0] sim_mem [NPEAK*NPEAK];
    logic [6:0]      pc_reg = 7'd64;
    logic [4:0]      kc_reg = 5'd1;

    t_label_word label_q [$];
    int          err_count = 0;
    int          cycle_count = 0;
    int          gap_pct = 12;
    int          stall_pct = 82;
    int          rand_items = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("[peak_cluster_selector_core] ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch @%0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic longint pair_avg(longint s, int k);
        return (k != 0) ? s / k : 0;
    endfunction

    // works out the label word stream of one run; returns the word count
    function automatic int predict_labels();
        int      n, c, j, cur, kept, idx;
        longint  sum [NCLUS][NCLUS];
        int      cnt [NCLUS][NCLUS];
        longint  intra [NCLUS];
        longint  sil [NCLUS];
        int      ord [NCLUS];
        bit      keep [NCLUS];
        longint  self_a, oth, m, diff, mag, th, sth, lo, hi;
        t_label_word w;
        n = (pc_reg == 0) ? 1 : ((pc_reg > NPEAK) ? NPEAK : int'(pc_reg));
        c = 0;
        for (int i = 0; i < n; i++)
            if (int'(lab_mem[i]) + 1 > c) c = int'(lab_mem[i]) + 1;
        for (int a = 0; a < NCLUS; a++) begin
            for (int b = 0; b < NCLUS; b++) begin
                sum[a][b] = 0;
                cnt[a][b] = 0;
            end
            intra[a] = 0;
            sil[a] = 0;
            ord[a] = a;
            keep[a] = 1'b1;
        end
        for (int i = 0; i < n; i++)
            for (int k = 0; k < n; k++)
                if (i != k) begin
                    sum[lab_mem[i]][lab_mem[k]] += sim_mem[i*NPEAK + k];
                    cnt[lab_mem[i]][lab_mem[k]] += 1;
                end
        for (int k = 0; k < c; k++) begin
            self_a = pair_avg(sum[k][k], cnt[k][k]);
            intra[k] = self_a;
            if (c >= 2) begin
                oth = 0;
                for (int i = 0; i < c; i++)
                    if (i != k) oth += pair_avg(sum[k][i], cnt[k][i]);
                oth = oth / (c - 1);
                m = (self_a > oth) ? self_a : oth;
                if (m != 0) begin
                    diff = self_a - oth;
                    mag = ((diff < 0 ? -diff : diff) << SIMW) / m;
                    sil[k] = (diff < 0) ? -mag : mag;
                    if (sil[k] > 65535) sil[k] = 65535;
                    if (sil[k] < -65536) sil[k] = -65536;
                end
            end
        end
        // stable ascending order of intra-cluster similarity
        for (int i = 1; i < c; i++) begin
            cur = ord[i];
            j = i;
            while (j > 0 && intra[ord[j-1]] > intra[cur]) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = cur;
        end
        if (kc_reg == 0) begin
            lo = (3 * 65536 + 5) / 10;
            hi = (6 * 65536 + 5) / 10;
            th = (intra[ord[0]] + intra[ord[c-1]]) >> 1;
            sth = 65536 / c;
            if (th > hi) th = hi;
            if (th < lo) th = lo;
            kept = 0;
            for (int k = 0; k < c; k++) begin
                if (intra[ord[k]] < th) keep[k] = 1'b0;
                if (sil[ord[k]] < sth) keep[k] = 1'b0;
                kept += keep[k];
            end
            if (kept == c) keep[0] = 1'b0;
        end else if (kc_reg < c) begin
            for (int k = 0; k < c - kc_reg; k++) keep[k] = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            w.peak = i[PKW-1:0];
            w.lab = 5'(lab_mem[i]);
            for (int k = 0; k < c; k++)
                if (ord[k] == int'(lab_mem[i])) begin
                    idx = k;
                    if (!keep[idx])
                        w.lab = (lab_mem[i] == 0) ? -5'sd1 : -$signed(5'(lab_mem[i]));
                    break;
                end
            w.last = (i == n - 1);
            label_q.push_back(w);
        end
        return n;
    endfunction

    // drives one word and holds it until accepted, then updates the predictor
    task automatic push_word(input t_op op, input logic [PKW-1:0] pi,
                             input logic [PKW-1:0] oi, input logic [LBW-1:0] lab,
                             input logic [SIMW-1:0] sim, output int nres);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_peak_index <= pi;
        i_other_index <= oi;
        i_cluster_label <= lab;
        i_similarity_value <= sim;
        do @(posedge i_clk); while (o_stall);
        nres = 0;
        case (op)
            OP_LOAD_LABEL: lab_mem[pi] = lab;
            OP_LOAD_SIM:   sim_mem[pi*NPEAK + oi] = sim;
            OP_RUN:        nres = predict_labels();
            default: ;
        endcase
    endtask

    // settings change only once the block has drained
    task automatic write_settings(input logic [6:0] pc, input logic [6:0] kc);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (label_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_PEAK_COUNT;
        i_cfg_data <= pc;
        @(posedge i_clk);
        pc_reg = pc;
        i_cfg_index <= CFG_KEEP_COUNT;
        i_cfg_data <= kc;
        @(posedge i_clk);
        kc_reg = kc[4:0];
        i_cfg_we <= 1'b0;
    endtask

    // result side: check each accepted word, then pick the next stall
    always @(posedge i_clk) begin
        t_label_word exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (label_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected word peak=%0d", o_out_peak));
            end else begin
                exp_w = label_q.pop_front();
                if (o_out_peak !== exp_w.peak)
                    flag_mismatch($sformatf("peak %0d, want %0d", o_out_peak, exp_w.peak));
                if (o_out_label !== exp_w.lab)
                    flag_mismatch($sformatf("peak %0d label %0d, want %0d",
                                            exp_w.peak, o_out_label, exp_w.lab));
                if (o_last !== exp_w.last)
                    flag_mismatch($sformatf("peak %0d last %0b, want %0b",
                                            exp_w.peak, o_last, exp_w.last));
            end
        end
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    initial begin
        t_stim_row rows [18];
        int        nres, base, n, cmax;
        logic [6:0] pc, kc;
        rows = '{
            '{1, 7'd2,   7'd1,  OP_LOAD_LABEL, 6'd0,  6'd0,  4'd0,  16'h0000, 0, 5'sd0, 5'sd0},
            '{0, 7'd0,   7'd0,  OP_LOAD_LABEL, 6'd1,  6'd0,  4'd0,  16'h0000, 0, 5'sd0, 5'sd0},
            '{0, 7'd0,   7'd0,  OP_RUN,        6'd0,  6'd0,  4'd0,  16'h0000, 1, 5'sd0, 5'sd0},
            '{1, 7'd0,   7'd0,  OP_RUN,        6'd0,  6'd0,  4'd0,  16'h0000, 1, -5'sd1, 5'sd0},
            '{0, 7'd0,   7'd0,  OP_LOAD_LABEL, 6'd0,  6'd0,  4'd15, 16'h0000, 0, 5'sd0, 5'sd0},
            '{0, 7'd0,   7'd0,  OP_RUN,        6'd0,  6'd0,  4'd0,  16'h0000, 1, -5'sd15, 5'sd0},
            '{0, 7'd0,   7'd0,  OP_LOAD_SIM,   6'd63, 6'd0,  4'd0,  16'hFFFF, 0, 5'sd0, 5'sd0},
            '{0, 7'd0,   7'd0,  OP_LOAD_SIM,   6'd0,  6'd63, 4'd0,  16'h0000, 0, 5'sd0, 5'sd0},
            '{0, 7'd0,   7'd0,  OP_LOAD_SIM,   6'd1,  6'd0,  4'd0,  16'hFFFF, 0, 5'sd0, 5'sd0},
            '{0, 7'd0,   7'd0,  OP_LOAD_SIM,   6'd0,  6'd1,  4'd0,  16'h0000, 0, 5'sd0, 5'sd0},
            '{0, 7'd0,   7'd0,  OP_LOAD_LABEL, 6'd1,  6'd0,  4'd5,  16'h0000, 0, 5'sd0, 5'sd0},
            '{1, 7'd2,   7'd0,  OP_RUN,        6'd0,  6'd0,  4'd0,  16'h0000, 0, 5'sd0, 5'sd0},
            '{1, 7'd2,   7'd31, OP_RUN,        6'd0,  6'd0,  4'd0,  16'h0000, 0, 5'sd0, 5'sd0},
            '{0, 7'd0,   7'd0,  OP_NOP,        6'd63, 6'd63, 4'd15, 16'hFFFF, 0, 5'sd0, 5'sd0},
            '{0, 7'd0,   7'd0,  OP_LOAD_LABEL, 6'd63, 6'd0,  4'd15, 16'h0000, 0, 5'sd0, 5'sd0},
            '{1, 7'd16,  7'd16, OP_RUN,        6'd0,  6'd0,  4'd0,  16'h0000, 0, 5'sd0, 5'sd0},
            '{1, 7'd16,  7'd2,  OP_RUN,        6'd0,  6'd0,  4'd0,  16'h0000, 0, 5'sd0, 5'sd0},
            '{1, 7'd16,  7'd0,  OP_RUN,        6'd0,  6'd0,  4'd0,  16'h0000, 0, 5'sd0, 5'sd0}
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the part of both stores that runs can reach
        for (int p = 0; p < TB_PEAKS; p++)
            push_word(OP_LOAD_LABEL, p[PKW-1:0], 6'($urandom), 4'($urandom_range(15)),
                      16'($urandom), nres);
        for (int a = 0; a < TB_PEAKS; a++)
            for (int b = 0; b < TB_PEAKS; b++)
                push_word(OP_LOAD_SIM, a[PKW-1:0], b[PKW-1:0], 4'($urandom),
                          16'($urandom), nres);

        foreach (rows[r]) begin
            if (rows[r].cfg) write_settings(rows[r].pc, rows[r].kc);
            push_word(rows[r].op, rows[r].pi, rows[r].oi, rows[r].lab, rows[r].sim, nres);
            if (rows[r].typed && nres > 0) begin
                base = label_q.size() - nres;
                label_q[base].lab = rows[r].l0;
                if (nres > 1) label_q[base + 1].lab = rows[r].l1;
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            gap_pct   = (phase == 0) ? 12 : ((phase == 1) ? 82 : 0);
            stall_pct = (phase == 0) ? 82 : ((phase == 1) ? 12 : 0);
            while (rand_items < RAND_ITEMS * (phase + 1) / 3) begin
                if ($urandom_range(1) == 0) begin
                    if ($urandom_range(29) == 0) pc = 7'($urandom_range(13, TB_PEAKS));
                    else                         pc = 7'($urandom_range(0, 12));
                    kc = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 17));
                    write_settings(pc, kc);
                end
                n = (pc_reg == 0) ? 1 : ((pc_reg > NPEAK) ? NPEAK : int'(pc_reg));
                cmax = $urandom_range(0, 15);
                // well-formed sequence: labels of the used peaks, a few pair
                // similarities, some noise, then a run word
                if (n <= 16)
                    for (int p = 0; p < n; p++) begin
                        push_word(OP_LOAD_LABEL, p[PKW-1:0], 6'($urandom),
                                  4'($urandom_range(0, cmax)), 16'($urandom), nres);
                        rand_items++;
                    end
                repeat ($urandom_range(0, 8)) begin
                    push_word(OP_LOAD_SIM, 6'($urandom_range(0, n - 1)),
                              6'($urandom_range(0, n - 1)), 4'($urandom),
                              ($urandom_range(1) != 0) ? 16'($urandom_range(16384, 49152))
                                                       : 16'($urandom), nres);
                    rand_items++;
                end
                repeat ($urandom_range(0, 2)) begin
                    push_word(t_op'($urandom_range(0, 3)), 6'($urandom), 6'($urandom),
                              4'($urandom), 16'($urandom), nres);
                    rand_items++;
                end
                push_word(OP_RUN, 6'($urandom), 6'($urandom), 4'($urandom),
                          16'($urandom), nres);
                rand_items++;
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (label_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[peak_cluster_selector_core] OK");
        end else begin
            $display("[peak_cluster_selector_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pcs_pkg.sv
rtl/pcs_ram.sv
rtl/pcs_div.sv
rtl/pcs_dp.sv
rtl/pcs_ctrl.sv
rtl/peak_cluster_selector_core.sv
bench/peak_cluster_selector_core_test.sv
